@@ sv/ccbf_pkg.sv @@
// shared types, widths, direction codes and segment classification functions
package ccbf_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int INDEX_WIDTH = 16;
	localparam int DELTA_W     = COORD_WIDTH + 1;
	localparam int MAG_W       = COORD_WIDTH;
	localparam int SUM_W       = MAG_W + 1;
	localparam int SQ_W        = 2 * SUM_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef logic [2:0] code_t;

	// freeman directions, counter-clockwise from +x
	localparam code_t CODE_E  = 3'd0;
	localparam code_t CODE_NE = 3'd1;
	localparam code_t CODE_N  = 3'd2;
	localparam code_t CODE_NW = 3'd3;
	localparam code_t CODE_W  = 3'd4;
	localparam code_t CODE_SW = 3'd5;
	localparam code_t CODE_S  = 3'd6;
	localparam code_t CODE_SE = 3'd7;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DELTA_W-1:0]     delta_t;
	typedef logic [INDEX_WIDTH-1:0]        index_t;

	typedef struct packed {
		logic   lone;
		logic   first;
		logic   fin;
		index_t idx;
	} meta_t;

	typedef struct packed {
		delta_t dx;
		delta_t dy;
	} step_t;

	typedef struct packed {
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic [SUM_W-1:0] s;
		logic             x_pos;
		logic             y_pos;
	} mag_t;

	typedef struct packed {
		logic [SQ_W-1:0] ssq;
		logic [SQ_W-1:0] ax2;
		logic [SQ_W-1:0] ay2;
		logic            x_pos;
		logic            y_pos;
		logic            zero;
	} prod_t;

	typedef struct packed {
		meta_t meta;
		code_t seg_code;
		code_t cls_code;
	} entry_t;

	typedef struct packed {
		index_t idx;
		code_t  code;
		logic   brk;
		logic   done;
	} res_t;

	function automatic mag_t step_mag(step_t st);
		mag_t             m;
		logic [DELTA_W-1:0] ux;
		logic [DELTA_W-1:0] uy;
		ux = st.dx[DELTA_W-1] ? DELTA_W'(-st.dx) : DELTA_W'(st.dx);
		uy = st.dy[DELTA_W-1] ? DELTA_W'(-st.dy) : DELTA_W'(st.dy);
		m.ax    = ux[MAG_W-1:0];
		m.ay    = uy[MAG_W-1:0];
		m.s     = SUM_W'(ux[MAG_W-1:0]) + SUM_W'(uy[MAG_W-1:0]);
		m.x_pos = !st.dx[DELTA_W-1] && (st.dx != '0);
		m.y_pos = !st.dy[DELTA_W-1] && (st.dy != '0);
		return m;
	endfunction

	function automatic prod_t mag_square(mag_t m);
		prod_t              p;
		logic [2*MAG_W-1:0] sqx;
		logic [2*MAG_W-1:0] sqy;
		sqx     = m.ax * m.ax;
		sqy     = m.ay * m.ay;
		p.ssq   = m.s * m.s;
		p.ax2   = SQ_W'({sqx, 1'b0});
		p.ay2   = SQ_W'({sqy, 1'b0});
		p.x_pos = m.x_pos;
		p.y_pos = m.y_pos;
		p.zero  = (m.s == '0);
		return p;
	endfunction

	// (|a|+|b|)^2 < 2a^2 : within 22.5 degrees of the x axis, same for y
	function automatic code_t prod_code(prod_t p);
		code_t c;
		if (p.zero) begin
			c = CODE_N;
		end else if (p.ssq < p.ax2) begin
			c = p.x_pos ? CODE_E : CODE_W;
		end else if (p.ssq < p.ay2) begin
			c = p.y_pos ? CODE_N : CODE_S;
		end else if (p.x_pos) begin
			c = p.y_pos ? CODE_NE : CODE_SE;
		end else begin
			c = p.y_pos ? CODE_NW : CODE_SW;
		end
		return c;
	endfunction

endpackage

@@ sv/ccbf_if.sv @@
// point and breakpoint channel interfaces
interface ccbf_point_if;
	logic                   valid;
	logic                   ready;
	ccbf_pkg::coord_t       point_x;
	ccbf_pkg::coord_t       point_y;
	logic                   final_point;

	modport source (output valid, output point_x, output point_y, output final_point,
		input ready);
	modport sink (input valid, input point_x, input point_y, input final_point,
		output ready);
endinterface

interface ccbf_result_if;
	logic                   valid;
	logic                   ready;
	ccbf_pkg::index_t       break_index;
	ccbf_pkg::code_t        segment_code;
	logic                   is_break;
	logic                   contour_done;

	modport source (output valid, output break_index, output segment_code,
		output is_break, output contour_done, input ready);
	modport sink (input valid, input break_index, input segment_code,
		input is_break, input contour_done, output ready);
endinterface

@@ sv/ccbf_front.sv @@
// front part: contour tracking, segment deltas and three-stage sector classification
module ccbf_front (
	input  logic               clk,
	input  logic               arst_n,
	ccbf_point_if.sink         point_in,
	output logic               q_valid,
	input  logic               q_ready,
	output ccbf_pkg::entry_t   q_entry
);

	ccbf_pkg::coord_t start_x_q, start_y_q, prior_x_q, prior_y_q;
	ccbf_pkg::index_t cnt_q;

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;
	logic acc, emit;

	ccbf_pkg::meta_t meta_in, meta_s1, meta_s2, meta_s3;
	ccbf_pkg::step_t seg_in, cls_in, seg_s1, cls_s1;
	ccbf_pkg::mag_t  seg_s2, cls_s2;
	ccbf_pkg::prod_t seg_s3, cls_s3;

	assign en_s3 = !v_s3 || q_ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign point_in.ready = en_s1;
	assign acc  = point_in.valid && en_s1;
	// a contour's first point yields nothing on its own unless it is also its final point
	assign emit = (cnt_q != '0) || point_in.final_point;

	always_comb begin
		meta_in.lone  = (cnt_q == '0);
		meta_in.first = (cnt_q == ccbf_pkg::INDEX_WIDTH'(1));
		meta_in.fin   = point_in.final_point;
		meta_in.idx   = cnt_q;
		seg_in.dx = ccbf_pkg::DELTA_W'(point_in.point_x) - ccbf_pkg::DELTA_W'(prior_x_q);
		seg_in.dy = ccbf_pkg::DELTA_W'(point_in.point_y) - ccbf_pkg::DELTA_W'(prior_y_q);
		cls_in.dx = ccbf_pkg::DELTA_W'(start_x_q) - ccbf_pkg::DELTA_W'(point_in.point_x);
		cls_in.dy = ccbf_pkg::DELTA_W'(start_y_q) - ccbf_pkg::DELTA_W'(point_in.point_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			prior_x_q <= '0;
			prior_y_q <= '0;
			cnt_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= acc && emit;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (acc) begin
				if (cnt_q == '0) begin
					if (!point_in.final_point) begin
						start_x_q <= point_in.point_x;
						start_y_q <= point_in.point_y;
						prior_x_q <= point_in.point_x;
						prior_y_q <= point_in.point_y;
						cnt_q     <= ccbf_pkg::INDEX_WIDTH'(1);
					end
				end else if (point_in.final_point) begin
					cnt_q <= '0;
				end else begin
					prior_x_q <= point_in.point_x;
					prior_y_q <= point_in.point_y;
					cnt_q     <= (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			meta_s1 <= meta_in;
			seg_s1  <= seg_in;
			cls_s1  <= cls_in;
		end
		if (en_s2) begin
			meta_s2 <= meta_s1;
			seg_s2  <= ccbf_pkg::step_mag(seg_s1);
			cls_s2  <= ccbf_pkg::step_mag(cls_s1);
		end
		if (en_s3) begin
			meta_s3 <= meta_s2;
			seg_s3  <= ccbf_pkg::mag_square(seg_s2);
			cls_s3  <= ccbf_pkg::mag_square(cls_s2);
		end
	end

	assign q_valid          = v_s3;
	assign q_entry.meta     = meta_s3;
	assign q_entry.seg_code = ccbf_pkg::prod_code(seg_s3);
	assign q_entry.cls_code = ccbf_pkg::prod_code(cls_s3);

endmodule

@@ sv/ccbf_fifo.sv @@
// short first-word-fall-through queue between front and back
module ccbf_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  ccbf_pkg::entry_t wr_entry,
	output logic             rd_valid,
	input  logic             rd_ready,
	output ccbf_pkg::entry_t rd_entry
);

	ccbf_pkg::entry_t                slot_q [ccbf_pkg::QUEUE_DEPTH];
	logic [ccbf_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [ccbf_pkg::QPTR_W:0]       fill_q;
	logic                            push, pop;

	assign wr_ready = (fill_q < (ccbf_pkg::QPTR_W + 1)'(ccbf_pkg::QUEUE_DEPTH));
	assign rd_valid = (fill_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

@@ sv/ccbf_back.sv @@
// back part: code comparison, result list and output register
module ccbf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_ready,
	input  ccbf_pkg::entry_t q_entry,
	ccbf_result_if.source    result_out
);

	ccbf_pkg::code_t prior_code_q, start_code_q;
	ccbf_pkg::res_t  pend_q [3];
	logic [1:0]      pend_n_q;
	ccbf_pkg::res_t  out_q;
	logic            out_valid_q;

	ccbf_pkg::res_t  gen [3];
	ccbf_pkg::res_t  r_seg, r_cls, r_end;
	ccbf_pkg::code_t start_new;
	logic            seg_hit, cls_hit, end_hit;
	logic [1:0]      gen_n;
	logic            take_out, move, pop;

	assign take_out = !out_valid_q || result_out.ready;
	assign move     = take_out && (pend_n_q != 2'd0);
	assign pop      = q_valid && ((pend_n_q == 2'd0) || ((pend_n_q == 2'd1) && take_out));
	assign q_ready  = pop;

	always_comb begin
		start_new = q_entry.meta.first ? q_entry.seg_code : start_code_q;
		seg_hit   = !q_entry.meta.lone && !q_entry.meta.first
			&& (q_entry.seg_code != prior_code_q);
		cls_hit   = !q_entry.meta.lone && q_entry.meta.fin
			&& (q_entry.cls_code != q_entry.seg_code);
		end_hit   = q_entry.meta.lone || q_entry.meta.fin;

		r_seg.idx  = q_entry.meta.idx - 1'b1;
		r_seg.code = q_entry.seg_code;
		r_seg.brk  = 1'b1;
		r_seg.done = 1'b0;

		r_cls.idx  = q_entry.meta.idx;
		r_cls.code = q_entry.cls_code;
		r_cls.brk  = 1'b1;
		r_cls.done = 1'b0;

		// index 0 closes the contour, as a breakpoint or as a bare marker
		r_end.idx  = '0;
		r_end.done = 1'b1;
		if (!q_entry.meta.lone && (start_new != q_entry.cls_code)) begin
			r_end.code = start_new;
			r_end.brk  = 1'b1;
		end else begin
			r_end.code = ccbf_pkg::CODE_E;
			r_end.brk  = 1'b0;
		end

		gen[0] = seg_hit ? r_seg : (cls_hit ? r_cls : r_end);
		gen[1] = (seg_hit && cls_hit) ? r_cls : r_end;
		gen[2] = r_end;
		gen_n  = 2'(seg_hit) + 2'(cls_hit) + 2'(end_hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_code_q <= ccbf_pkg::CODE_E;
			start_code_q <= ccbf_pkg::CODE_E;
			pend_n_q     <= 2'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take_out) begin
				out_valid_q <= (pend_n_q != 2'd0);
			end
			if (pop) begin
				pend_n_q <= gen_n;
				if (!q_entry.meta.lone) begin
					prior_code_q <= q_entry.seg_code;
					if (q_entry.meta.first) begin
						start_code_q <= q_entry.seg_code;
					end
				end
			end else if (move) begin
				pend_n_q <= pend_n_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q <= pend_q[0];
		end
		if (pop) begin
			pend_q <= gen;
		end else if (move) begin
			pend_q[0] <= pend_q[1];
			pend_q[1] <= pend_q[2];
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.break_index  = out_q.idx;
	assign result_out.segment_code = out_q.code;
	assign result_out.is_break     = out_q.brk;
	assign result_out.contour_done = out_q.done;

endmodule

@@ sv/chain_code_breakpoint_finder.sv @@
// chain code breakpoint finder: top level joining front, queue and back
// path: an item's first result passes the front stages, queue, result list and output register
// throughput: one point per cycle while the output takes results; each result holds
//   the output for one cycle; a final point with three results sends them in turn
// the front's three classification stages and the four-entry queue absorb such bursts
// reset: arst_n clears contour state, codes, pipeline valids, queue and output register
module chain_code_breakpoint_finder (
	input  logic           clk,
	input  logic           arst_n,
	ccbf_point_if.sink     point_in,
	ccbf_result_if.source  result_out
);

	// front to queue
	logic             fq_valid, fq_ready;
	ccbf_pkg::entry_t fq_entry;

	// queue to back
	logic             qb_valid, qb_ready;
	ccbf_pkg::entry_t qb_entry;

	// front: tracks start and prior point, forms the segment and closing deltas and
	// classifies both into freeman codes over three registered stages
	ccbf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.point_in (point_in),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_entry  (fq_entry)
	);

	// decoupling queue, so a burst of results does not stall the point stream at once
	ccbf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_entry (fq_entry),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_entry (qb_entry)
	);

	// back: compares codes, builds up to three results per item and drains them
	// through the output register
	ccbf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (qb_valid),
		.q_ready    (qb_ready),
		.q_entry    (qb_entry),
		.result_out (result_out)
	);

endmodule

@@ sv/ccbf_checker.sv @@
// port-level checks for the chain code breakpoint finder, bound to the top level
module ccbf_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input ccbf_pkg::index_t break_index,
	input ccbf_pkg::code_t  segment_code,
	input logic             is_break,
	input logic             contour_done
);

	// a stalled item stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// a stalled item keeps its contents
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(break_index) && $stable(segment_code)
			&& $stable(is_break) && $stable(contour_done))
		else $error("result changed while stalled");

	// the closing item always reports index 0; as a bare marker it carries code 0
	a_end_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && contour_done |-> (break_index == '0)
			&& (is_break || (segment_code == ccbf_pkg::CODE_E)))
		else $error("malformed end of contour item");

	// anything before the end of a contour is a real breakpoint
	a_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !contour_done |-> is_break)
		else $error("bare marker before end of contour");

endmodule

bind chain_code_breakpoint_finder ccbf_checker u_ccbf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result_out.valid),
	.out_ready    (result_out.ready),
	.break_index  (result_out.break_index),
	.segment_code (result_out.segment_code),
	.is_break     (result_out.is_break),
	.contour_done (result_out.contour_done)
);
